[hdl/ilu_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ilu_pkg
// Shared types, register codes and fixed-point helpers for the lens undistorter.
// ----------------------------------------------------------------------------
package ilu_pkg;

    // default number of inverse-model iterations
    localparam int ITER_DEFAULT = 5;
    // quotient bits produced by the long dividers (magnitude below 2^33)
    localparam int QBITS = 33;

    // q4.28 value and a wider working value for unsaturated sums
    typedef logic signed [31:0] q_t;
    typedef logic signed [39:0] wide_t;

    // q4.28 one
    localparam wide_t QONE = 40'sd268435456;

    typedef struct packed {
        logic ovf;
        q_t   val;
    } sat_t;

    typedef struct packed {
        q_t k1;
        q_t k2;
        q_t k3;
        q_t p1;
        q_t p2;
    } coef_t;

    // values carried alongside an item through every iteration
    typedef struct packed {
        q_t   x0;
        q_t   y0;
        logic flag;
        logic dead;
    } side_t;

    typedef struct packed {
        q_t    x;
        q_t    y;
        side_t side;
    } item_t;

    typedef enum logic [2:0] {
        REG_FOCAL_X   = 3'd0,
        REG_FOCAL_Y   = 3'd1,
        REG_PRINCIPAL = 3'd2,
        REG_K1        = 3'd3,
        REG_K2        = 3'd4,
        REG_P1        = 3'd5,
        REG_P2        = 3'd6,
        REG_K3        = 3'd7
    } cfg_reg_t;

    // q4.28 product, floor shift by the fraction width
    function automatic wide_t qmul(input q_t a, input q_t b);
        logic signed [63:0] p;
        p = a * b;
        return wide_t'(p >>> 28);
    endfunction

    // saturate a working value to 32 bits signed
    function automatic sat_t sat32(input wide_t v);
        sat_t r;
        if (v > 40'sd2147483647)
        begin
            r.ovf = 1'b1;
            r.val = 32'sh7fffffff;
        end
        else if (v < -40'sd2147483648)
        begin
            r.ovf = 1'b1;
            r.val = 32'sh80000000;
        end
        else
        begin
            r.ovf = 1'b0;
            r.val = v[31:0];
        end
        return r;
    endfunction

endpackage

[hdl/ilu_div2.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ilu_div2
// Two-lane pipelined restoring divider, one quotient bit per stage, with a
// signed quotient truncated toward zero and saturated to 32 bits.
// ----------------------------------------------------------------------------
module ilu_div2
    import ilu_pkg::*;
#(
    parameter int NSW = 60,
    parameter int DSW = 32,
    parameter int PW  = 1
)
(
    input  logic           clk,
    input  logic           rst_n,
    input  logic           en,
    input  logic           in_valid,
    input  logic [NSW-1:0] num_a,
    input  logic [NSW-1:0] num_b,
    input  logic [DSW-1:0] den_a,
    input  logic [DSW-1:0] den_b,
    input  logic [PW-1:0]  in_pay,
    output logic           out_valid,
    output q_t             q_a,
    output q_t             q_b,
    output logic           ovf_a,
    output logic           ovf_b,
    output logic [PW-1:0]  out_pay
);

    localparam int QW = QBITS;

    logic [QW:0]    v_reg;
    logic [PW-1:0]  pay_reg [QW+1];
    logic [DSW-1:0] rem_reg [2][QW+1];
    logic [QW-1:0]  lo_reg  [2][QW+1];
    logic [QW-1:0]  quo_reg [2][QW+1];
    logic [DSW-1:0] dm_reg  [2][QW+1];
    logic           neg_reg [2][QW+1];
    logic           ovf_reg [2][QW+1];

    logic [NSW-1:0] num_w [2];
    logic [DSW-1:0] den_w [2];
    logic [NSW-1:0] nmag  [2];
    logic [NSW-1:0] nhi   [2];
    logic [DSW-1:0] dmag  [2];
    q_t             qv    [2];
    logic           qo    [2];

    assign num_w[0] = num_a;
    assign num_w[1] = num_b;
    assign den_w[0] = den_a;
    assign den_w[1] = den_b;

    // magnitudes and quotient overflow check
    always_comb
    begin
        for (int l = 0; l < 2; l++)
        begin
            nmag[l] = num_w[l][NSW-1] ? (~num_w[l]) + NSW'(1) : num_w[l];
            dmag[l] = den_w[l][DSW-1] ? (~den_w[l]) + DSW'(1) : den_w[l];
            nhi[l]  = nmag[l] >> QW;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            v_reg[0] <= 1'b0;
        else if (en)
            v_reg[0] <= in_valid;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            pay_reg[0] <= in_pay;
            for (int l = 0; l < 2; l++)
            begin
                rem_reg[l][0] <= nhi[l][DSW-1:0];
                lo_reg[l][0]  <= nmag[l][QW-1:0];
                quo_reg[l][0] <= '0;
                dm_reg[l][0]  <= dmag[l];
                neg_reg[l][0] <= num_w[l][NSW-1] ^ den_w[l][DSW-1];
                ovf_reg[l][0] <= nhi[l] >= {{(NSW-DSW){1'b0}}, dmag[l]};
            end
        end
    end

    // one quotient bit per stage
    for (genvar k = 1; k <= QW; k++)
    begin : g_bit
        logic [DSW:0]   trial [2];
        logic           ge    [2];
        logic [DSW-1:0] rem_n [2];

        always_comb
        begin
            for (int l = 0; l < 2; l++)
            begin
                trial[l] = {rem_reg[l][k-1], lo_reg[l][k-1][QW-1]};
                ge[l]    = trial[l] >= {1'b0, dm_reg[l][k-1]};
                rem_n[l] = ge[l] ? DSW'(trial[l] - {1'b0, dm_reg[l][k-1]})
                                 : trial[l][DSW-1:0];
            end
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
                v_reg[k] <= 1'b0;
            else if (en)
                v_reg[k] <= v_reg[k-1];
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                pay_reg[k] <= pay_reg[k-1];
                for (int l = 0; l < 2; l++)
                begin
                    rem_reg[l][k] <= rem_n[l];
                    lo_reg[l][k]  <= {lo_reg[l][k-1][QW-2:0], 1'b0};
                    quo_reg[l][k] <= {quo_reg[l][k-1][QW-2:0], ge[l]};
                    dm_reg[l][k]  <= dm_reg[l][k-1];
                    neg_reg[l][k] <= neg_reg[l][k-1];
                    ovf_reg[l][k] <= ovf_reg[l][k-1];
                end
            end
        end
    end

    // apply sign and saturate to 32 bits
    always_comb
    begin
        for (int l = 0; l < 2; l++)
        begin
            if (neg_reg[l][QW])
            begin
                if (ovf_reg[l][QW] || (quo_reg[l][QW] > 33'd2147483648))
                begin
                    qv[l] = 32'sh80000000;
                    qo[l] = 1'b1;
                end
                else
                begin
                    qv[l] = q_t'(-$signed({1'b0, quo_reg[l][QW]}));
                    qo[l] = 1'b0;
                end
            end
            else
            begin
                if (ovf_reg[l][QW] || (quo_reg[l][QW] > 33'd2147483647))
                begin
                    qv[l] = 32'sh7fffffff;
                    qo[l] = 1'b1;
                end
                else
                begin
                    qv[l] = q_t'(quo_reg[l][QW][31:0]);
                    qo[l] = 1'b0;
                end
            end
        end
    end

    assign out_valid = v_reg[QW];
    assign out_pay   = pay_reg[QW];
    assign q_a       = qv[0];
    assign q_b       = qv[1];
    assign ovf_a     = qo[0];
    assign ovf_b     = qo[1];

endmodule

[hdl/ilu_iter.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ilu_iter
// One pipelined step of the inverse distortion model: radial polynomial,
// tangential terms and the divide by the radial factor.
// ----------------------------------------------------------------------------
module ilu_iter
    import ilu_pkg::*;
(
    input  logic  clk,
    input  logic  rst_n,
    input  logic  en,
    input  coef_t coef,
    input  logic  in_valid,
    input  item_t in_item,
    output logic  out_valid,
    output item_t out_item
);

    localparam int SW = $bits(side_t);

    // stage 1: squares and cross product
    logic  s1_v_reg;
    side_t s1_side_reg;
    wide_t s1_xx_reg, s1_yy_reg, s1_xy_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            s1_v_reg <= 1'b0;
        else if (en)
            s1_v_reg <= in_valid;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            s1_side_reg <= in_item.side;
            s1_xx_reg   <= qmul(in_item.x, in_item.x);
            s1_yy_reg   <= qmul(in_item.y, in_item.y);
            s1_xy_reg   <= qmul(in_item.x, in_item.y);
        end
    end

    // stage 2: radius and tangential operands
    sat_t r2_s, txy_s, tx_s, ty_s;
    side_t s2_side_next;

    always_comb
    begin
        r2_s  = sat32(s1_xx_reg + s1_yy_reg);
        txy_s = sat32(s1_xy_reg <<< 1);
        tx_s  = sat32(wide_t'(r2_s.val) + (s1_xx_reg <<< 1));
        ty_s  = sat32(wide_t'(r2_s.val) + (s1_yy_reg <<< 1));
        s2_side_next = s1_side_reg;
        s2_side_next.flag = s1_side_reg.flag | r2_s.ovf | txy_s.ovf | tx_s.ovf | ty_s.ovf;
    end

    logic  s2_v_reg;
    side_t s2_side_reg;
    q_t    s2_r2_reg, s2_txy_reg, s2_tx_reg, s2_ty_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            s2_v_reg <= 1'b0;
        else if (en)
            s2_v_reg <= s1_v_reg;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            s2_side_reg <= s2_side_next;
            s2_r2_reg   <= r2_s.val;
            s2_txy_reg  <= txy_s.val;
            s2_tx_reg   <= tx_s.val;
            s2_ty_reg   <= ty_s.val;
        end
    end

    // stage 3: innermost radial term and tangential shifts
    sat_t a_s, ddx_s, ddy_s;
    side_t s3_side_next;

    always_comb
    begin
        a_s   = sat32(qmul(coef.k3, s2_r2_reg) + wide_t'(coef.k2));
        ddx_s = sat32(qmul(coef.p1, s2_txy_reg) + qmul(coef.p2, s2_tx_reg));
        ddy_s = sat32(qmul(coef.p1, s2_ty_reg) + qmul(coef.p2, s2_txy_reg));
        s3_side_next = s2_side_reg;
        s3_side_next.flag = s2_side_reg.flag | a_s.ovf | ddx_s.ovf | ddy_s.ovf;
    end

    logic  s3_v_reg;
    side_t s3_side_reg;
    q_t    s3_r2_reg, s3_a_reg, s3_ddx_reg, s3_ddy_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            s3_v_reg <= 1'b0;
        else if (en)
            s3_v_reg <= s2_v_reg;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            s3_side_reg <= s3_side_next;
            s3_r2_reg   <= s2_r2_reg;
            s3_a_reg    <= a_s.val;
            s3_ddx_reg  <= ddx_s.val;
            s3_ddy_reg  <= ddy_s.val;
        end
    end

    // stage 4: middle radial term and corrected numerators
    sat_t b_s, nx_s, ny_s;
    side_t s4_side_next;

    always_comb
    begin
        b_s  = sat32(qmul(s3_a_reg, s3_r2_reg) + wide_t'(coef.k1));
        nx_s = sat32(wide_t'(s3_side_reg.x0) - wide_t'(s3_ddx_reg));
        ny_s = sat32(wide_t'(s3_side_reg.y0) - wide_t'(s3_ddy_reg));
        s4_side_next = s3_side_reg;
        s4_side_next.flag = s3_side_reg.flag | b_s.ovf | nx_s.ovf | ny_s.ovf;
    end

    logic  s4_v_reg;
    side_t s4_side_reg;
    q_t    s4_r2_reg, s4_b_reg, s4_nx_reg, s4_ny_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            s4_v_reg <= 1'b0;
        else if (en)
            s4_v_reg <= s3_v_reg;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            s4_side_reg <= s4_side_next;
            s4_r2_reg   <= s3_r2_reg;
            s4_b_reg    <= b_s.val;
            s4_nx_reg   <= nx_s.val;
            s4_ny_reg   <= ny_s.val;
        end
    end

    // stage 5: radial divisor
    sat_t den_s;
    side_t s5_side_next;

    always_comb
    begin
        den_s = sat32(QONE + qmul(s4_b_reg, s4_r2_reg));
        s5_side_next = s4_side_reg;
        s5_side_next.flag = s4_side_reg.flag | den_s.ovf;
    end

    logic  s5_v_reg;
    side_t s5_side_reg;
    q_t    s5_den_reg, s5_nx_reg, s5_ny_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            s5_v_reg <= 1'b0;
        else if (en)
            s5_v_reg <= s4_v_reg;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            s5_side_reg <= s5_side_next;
            s5_den_reg  <= den_s.val;
            s5_nx_reg   <= s4_nx_reg;
            s5_ny_reg   <= s4_ny_reg;
        end
    end

    // divide both numerators by the radial factor; a zero divisor kills the item
    side_t div_side_in, div_side_out;
    logic [SW-1:0] div_pay_out;
    q_t   qx, qy;
    logic ox, oy;

    always_comb
    begin
        div_side_in = s5_side_reg;
        div_side_in.dead = s5_side_reg.dead | (s5_den_reg == 32'sd0);
    end

    ilu_div2 #(
        .NSW (60),
        .DSW (32),
        .PW  (SW)
    ) u_div (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .in_valid  (s5_v_reg),
        .num_a     ({s5_nx_reg, 28'b0}),
        .num_b     ({s5_ny_reg, 28'b0}),
        .den_a     (s5_den_reg),
        .den_b     (s5_den_reg),
        .in_pay    (div_side_in),
        .out_valid (out_valid),
        .q_a       (qx),
        .q_b       (qy),
        .ovf_a     (ox),
        .ovf_b     (oy),
        .out_pay   (div_pay_out)
    );

    always_comb
    begin
        div_side_out = side_t'(div_pay_out);
        out_item.x = qx;
        out_item.y = qy;
        out_item.side = div_side_out;
        out_item.side.flag = div_side_out.flag | ox | oy;
    end

endmodule

[hdl/iterative_lens_undistort_top.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// iterative_lens_undistort_top
// Maps a distorted pixel coordinate to its undistorted position by inverting
// a five-coefficient radial/tangential lens model.
//
// Input stream s_*: one word per coordinate, pixel_x and pixel_y (unsigned
// q14.10). Output stream m_*: undist_x and undist_y (signed q16.10) in
// tdata and the out_of_range flag in tuser, one word per input word, in order.
// Config port: cfg_we writes cfg_data into register cfg_index;
// write only while no word is in flight.
// Throughput: one word per clock while m_tready is high, fully pipelined.
// Most pipeline stages are in the bit-per-stage dividers: 34 stages for
// normalization and 34 in the divider of each iteration.
// Reset clears all valid bits and loads the register defaults.
// When m_tready is low with a word waiting, the whole pipeline holds and
// s_tready drops; nothing is lost or repeated.
// ----------------------------------------------------------------------------
module iterative_lens_undistort_top
    import ilu_pkg::*;
#(
    parameter int ITERATIONS = ITER_DEFAULT
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [47:0] s_tdata,   // pixel_x [23:0], pixel_y [47:24]
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [55:0] m_tdata,   // undist_x [25:0], undist_y [51:26], zero [55:52]
    output logic [0:0]  m_tuser,   // out_of_range [0]
    input  logic        cfg_we,
    input  logic [2:0]  cfg_index,
    input  logic [47:0] cfg_data
);

    // configuration registers
    logic [23:0] focal_x_reg, focal_y_reg;
    logic [47:0] principal_reg;
    coef_t       coef_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            focal_x_reg   <= 24'd256000;
            focal_y_reg   <= 24'd256000;
            principal_reg <= '0;
            coef_reg      <= '0;
        end
        else if (cfg_we)
        begin
            unique case (cfg_reg_t'(cfg_index))
                REG_FOCAL_X:   focal_x_reg   <= cfg_data[23:0];
                REG_FOCAL_Y:   focal_y_reg   <= cfg_data[23:0];
                REG_PRINCIPAL: principal_reg <= cfg_data;
                REG_K1:        coef_reg.k1   <= cfg_data[31:0];
                REG_K2:        coef_reg.k2   <= cfg_data[31:0];
                REG_P1:        coef_reg.p1   <= cfg_data[31:0];
                REG_P2:        coef_reg.p2   <= cfg_data[31:0];
                REG_K3:        coef_reg.k3   <= cfg_data[31:0];
                default:       ;
            endcase
        end
    end

    logic [23:0] cx, cy;
    assign cx = principal_reg[23:0];
    assign cy = principal_reg[47:24];

    // pipeline advance: hold everything while a finished word waits
    logic out_v_reg;
    logic en;
    assign en       = !out_v_reg || m_tready;
    assign s_tready = en;

    // input stage: offsets from the principal point
    logic               in_v_reg, in_dead_reg;
    logic signed [24:0] dxp_reg, dyp_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            in_v_reg <= 1'b0;
        else if (en)
            in_v_reg <= s_tvalid;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            dxp_reg     <= $signed({1'b0, s_tdata[23:0]}) - $signed({1'b0, cx});
            dyp_reg     <= $signed({1'b0, s_tdata[47:24]}) - $signed({1'b0, cy});
            in_dead_reg <= (focal_x_reg == 24'd0) || (focal_y_reg == 24'd0);
        end
    end

    // normalization divide by the focal lengths
    logic  nrm_v, nrm_dead, nrm_ox, nrm_oy;
    q_t    nrm_x, nrm_y;
    item_t chain [ITERATIONS+1];
    logic [ITERATIONS:0] chain_v;

    ilu_div2 #(
        .NSW (51),
        .DSW (25),
        .PW  (1)
    ) u_norm (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .in_valid  (in_v_reg),
        .num_a     ({dxp_reg, 26'b0}),
        .num_b     ({dyp_reg, 26'b0}),
        .den_a     ({1'b0, focal_x_reg}),
        .den_b     ({1'b0, focal_y_reg}),
        .in_pay    (in_dead_reg),
        .out_valid (nrm_v),
        .q_a       (nrm_x),
        .q_b       (nrm_y),
        .ovf_a     (nrm_ox),
        .ovf_b     (nrm_oy),
        .out_pay   (nrm_dead)
    );

    // first iteration starts from the normalized point
    assign chain_v[0] = nrm_v;
    assign chain[0]   = {nrm_x, nrm_y, nrm_x, nrm_y, nrm_ox | nrm_oy, nrm_dead};

    // inverse model iterations
    for (genvar i = 0; i < ITERATIONS; i++)
    begin : g_iter
        ilu_iter u_iter (
            .clk       (clk),
            .rst_n     (rst_n),
            .en        (en),
            .coef      (coef_reg),
            .in_valid  (chain_v[i]),
            .in_item   (chain[i]),
            .out_valid (chain_v[i+1]),
            .out_item  (chain[i+1])
        );
    end

    // re-projection products
    logic               fin_v_reg, fin_flag_reg, fin_dead_reg;
    logic signed [56:0] fin_px_reg, fin_py_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            fin_v_reg <= 1'b0;
        else if (en)
            fin_v_reg <= chain_v[ITERATIONS];
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            fin_px_reg   <= chain[ITERATIONS].x * $signed({1'b0, focal_x_reg});
            fin_py_reg   <= chain[ITERATIONS].y * $signed({1'b0, focal_y_reg});
            fin_flag_reg <= chain[ITERATIONS].side.flag;
            fin_dead_reg <= chain[ITERATIONS].side.dead;
        end
    end

    // round, shift, add the principal point and saturate to 26 bits
    logic signed [63:0] ux_w, uy_w;
    logic signed [25:0] ux, uy;
    logic               sat_x, sat_y;

    always_comb
    begin
        ux_w = ((64'(fin_px_reg) + 64'sd33554432) >>> 26) + $signed({40'b0, cx});
        uy_w = ((64'(fin_py_reg) + 64'sd33554432) >>> 26) + $signed({40'b0, cy});
        sat_x = 1'b1;
        sat_y = 1'b1;
        if (ux_w > 64'sd33554431)
            ux = 26'sh1ffffff;
        else if (ux_w < -64'sd33554432)
            ux = 26'sh2000000;
        else
        begin
            ux = ux_w[25:0];
            sat_x = 1'b0;
        end
        if (uy_w > 64'sd33554431)
            uy = 26'sh1ffffff;
        else if (uy_w < -64'sd33554432)
            uy = 26'sh2000000;
        else
        begin
            uy = uy_w[25:0];
            sat_y = 1'b0;
        end
    end

    // output register
    logic [51:0] out_data_reg;
    logic        out_flag_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_v_reg <= 1'b0;
        else if (en)
            out_v_reg <= fin_v_reg;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            if (fin_dead_reg)
            begin
                out_data_reg <= '0;
                out_flag_reg <= 1'b1;
            end
            else
            begin
                out_data_reg <= {uy, ux};
                out_flag_reg <= fin_flag_reg | sat_x | sat_y;
            end
        end
    end

    assign m_tvalid = out_v_reg;
    assign m_tdata  = {4'b0, out_data_reg};
    assign m_tuser  = out_flag_reg;

`ifndef SYNTH
    // a dead item leaves as zero coordinates with the flag set
    a_dead_out: assert property (@(posedge clk) disable iff (!rst_n)
        en && fin_v_reg && fin_dead_reg |=> m_tuser[0] && (m_tdata == 56'd0))
        else $error("dead item not reported as zero with flag");

    // a waiting word blocks new input
    a_stall_block: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |-> !s_tready)
        else $error("input accepted while output stalled");

    // the re-projection stage holds while stalled
    a_stall_hold: assert property (@(posedge clk) disable iff (!rst_n)
        !en |=> $stable(fin_v_reg) && $stable(fin_px_reg))
        else $error("pipeline moved during stall");
`endif

endmodule

[test/iterative_lens_undistort_top_test.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// iterative_lens_undistort_top_test
// Self-checking bench for the iterative lens undistorter. A driver streams
// pixel words from a queue, a bit-exact predictor computes the undistorted
// pixel for every accepted word, and a monitor compares each output word in
// order. Phases change the lens registers while idle and vary idling on both
// sides, with one long output hold-off and one sender pause.
// ----------------------------------------------------------------------------
module iterative_lens_undistort_top_test;
    import ilu_pkg::*;

    localparam int  LATENCY   = 37 + 39 * ITER_DEFAULT;
    localparam int  CYC_LIMIT = 1500000;
    localparam int  N_ITER    = ITER_DEFAULT;

    typedef struct {
        logic signed [25:0] ux;
        logic signed [25:0] uy;
        logic               oor;
    } undist_t;

    logic        clk;
    logic        rst_n;
    logic        s_tvalid;
    logic        s_tready;
    logic [47:0] s_tdata;   // pixel_x [23:0], pixel_y [47:24]
    logic        m_tvalid;
    logic        m_tready;
    logic [55:0] m_tdata;   // undist_x [25:0], undist_y [51:26], zero [55:52]
    logic [0:0]  m_tuser;   // out_of_range [0]
    logic        cfg_we;
    cfg_reg_t    cfg_index;
    logic [47:0] cfg_data;

    // lens registers as the bench believes them
    logic [23:0] lens_fx, lens_fy;
    logic [47:0] lens_pp;
    q_t          lens_k1, lens_k2, lens_k3, lens_p1, lens_p2;

    logic [47:0] pixel_queue[$];
    undist_t     undist_queue[$];
    int          send_idle_pct, recv_stall_pct;
    logic        send_pause;
    logic        hold_kick;
    int          hold_cnt;
    int          mismatches = 0;
    int          cycles = 0;

    iterative_lens_undistort_top DUT
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    // clock
    initial
    begin
        clk = 1'b0;
        forever #6 clk = ~clk;
    end

    // saturate to a signed width, noting overflow
    function automatic longint clip(input longint v, input int bits, inout bit ovf);
        longint hi;
        longint lo;
        hi = (longint'(1) <<< (bits - 1)) - 1;
        lo = -hi - 1;
        if (v > hi)
        begin
            ovf = 1'b1;
            return hi;
        end
        if (v < lo)
        begin
            ovf = 1'b1;
            return lo;
        end
        return v;
    endfunction

    function automatic longint fixmul(input longint a, input longint b);
        return (a * b) >>> 28;
    endfunction

    // undistorted pixel for one distorted pixel under the current lens
    function automatic undist_t undistort(input logic [47:0] pix);
        undist_t r;
        bit      ovf;
        longint  cx, cy, fx, fy, x0, y0, x, y;
        longint  xx, yy, xy, r2, a, b, den, txy, tx, ty, ddx, ddy, nx, ny;
        ovf = 1'b0;
        cx = longint'(lens_pp[23:0]);
        cy = longint'(lens_pp[47:24]);
        fx = longint'(lens_fx);
        fy = longint'(lens_fy);
        r.ux = '0;
        r.uy = '0;
        r.oor = 1'b1;
        if (fx == 0 || fy == 0)
            return r;
        x0 = clip(((longint'(pix[23:0]) - cx) * (longint'(1) <<< 26)) / fx, 32, ovf);
        y0 = clip(((longint'(pix[47:24]) - cy) * (longint'(1) <<< 26)) / fy, 32, ovf);
        x = x0;
        y = y0;
        for (int i = 0; i < N_ITER; i++)
        begin
            xx  = fixmul(x, x);
            yy  = fixmul(y, y);
            xy  = fixmul(x, y);
            r2  = clip(xx + yy, 32, ovf);
            a   = clip(fixmul(lens_k3, r2) + lens_k2, 32, ovf);
            b   = clip(fixmul(a, r2) + lens_k1, 32, ovf);
            den = clip((longint'(1) <<< 28) + fixmul(b, r2), 32, ovf);
            txy = clip(2 * xy, 32, ovf);
            tx  = clip(r2 + 2 * xx, 32, ovf);
            ty  = clip(r2 + 2 * yy, 32, ovf);
            ddx = clip(fixmul(lens_p1, txy) + fixmul(lens_p2, tx), 32, ovf);
            ddy = clip(fixmul(lens_p1, ty) + fixmul(lens_p2, txy), 32, ovf);
            nx  = clip(x0 - ddx, 32, ovf);
            ny  = clip(y0 - ddy, 32, ovf);
            // zero radial divisor aborts with the flag
            if (den == 0)
                return r;
            x = clip((nx * (longint'(1) <<< 28)) / den, 32, ovf);
            y = clip((ny * (longint'(1) <<< 28)) / den, 32, ovf);
        end
        r.ux = 26'(clip(((x * fx + (longint'(1) <<< 25)) >>> 26) + cx, 26, ovf));
        r.uy = 26'(clip(((y * fy + (longint'(1) <<< 25)) >>> 26) + cy, 26, ovf));
        r.oor = ovf;
        return r;
    endfunction

    // input driver: predicts on acceptance, offers the next word
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s_tvalid <= 1'b0;
            s_tdata  <= '0;
        end
        else
        begin
            if (s_tvalid && s_tready)
                undist_queue.push_back(undistort(s_tdata));
            if (!s_tvalid || s_tready)
            begin
                if (pixel_queue.size() > 0 && !send_pause
                    && $urandom_range(99) >= send_idle_pct)
                begin
                    s_tdata  <= pixel_queue.pop_front();
                    s_tvalid <= 1'b1;
                end
                else
                    s_tvalid <= 1'b0;
            end
        end
    end

    // output ready with random stalls and a long hold-off on request
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            m_tready <= 1'b0;
            hold_cnt <= 0;
        end
        else if (hold_kick && hold_cnt == 0)
        begin
            hold_cnt <= 800;
            m_tready <= 1'b0;
        end
        else if (hold_cnt > 0)
        begin
            hold_cnt <= hold_cnt - 1;
            m_tready <= (hold_cnt == 1);
        end
        else
            m_tready <= ($urandom_range(99) >= recv_stall_pct);
    end

    // output monitor
    always @(posedge clk)
    begin
        if (rst_n && m_tvalid && m_tready)
        begin
            if (undist_queue.size() == 0)
            begin
                $display("%0t: unexpected word x=%0d y=%0d oor=%0b", $realtime,
                         $signed(m_tdata[25:0]), $signed(m_tdata[51:26]), m_tuser[0]);
                mismatches++;
            end
            else
            begin
                undist_t e;
                e = undist_queue.pop_front();
                if (m_tdata[25:0] !== e.ux || m_tdata[51:26] !== e.uy
                    || m_tuser[0] !== e.oor)
                begin
                    $display("%0t: expected x=%0d y=%0d oor=%0b, got x=%0d y=%0d oor=%0b",
                             $realtime, e.ux, e.uy, e.oor, $signed(m_tdata[25:0]),
                             $signed(m_tdata[51:26]), m_tuser[0]);
                    mismatches++;
                end
            end
        end
    end

    // timeout
    always @(posedge clk)
    begin
        cycles++;
        if (cycles > CYC_LIMIT)
        begin
            $display("end of test: mismatches");
            $finish;
        end
    end

    task automatic wait_drained();
        while (pixel_queue.size() > 0 || s_tvalid || undist_queue.size() > 0)
            @(posedge clk);
        repeat (LATENCY + 20) @(posedge clk);
    endtask

    task automatic write_reg(input cfg_reg_t idx, input logic [47:0] val);
        @(posedge clk);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        case (idx)
            REG_FOCAL_X:   lens_fx = val[23:0];
            REG_FOCAL_Y:   lens_fy = val[23:0];
            REG_PRINCIPAL: lens_pp = val;
            REG_K1:        lens_k1 = val[31:0];
            REG_K2:        lens_k2 = val[31:0];
            REG_P1:        lens_p1 = val[31:0];
            REG_P2:        lens_p2 = val[31:0];
            REG_K3:        lens_k3 = val[31:0];
            default: ;
        endcase
        @(posedge clk);
        cfg_we <= 1'b0;
    endtask

    task automatic write_lens(input logic [23:0] fx, input logic [23:0] fy,
                              input logic [47:0] pp, input q_t k1, input q_t k2,
                              input q_t k3, input q_t p1, input q_t p2);
        write_reg(REG_FOCAL_X, {24'h0, fx});
        write_reg(REG_FOCAL_Y, {24'h0, fy});
        write_reg(REG_PRINCIPAL, pp);
        write_reg(REG_K1, {16'h0, k1});
        write_reg(REG_K2, {16'h0, k2});
        write_reg(REG_K3, {16'h0, k3});
        write_reg(REG_P1, {16'h0, p1});
        write_reg(REG_P2, {16'h0, p2});
    endtask

    function automatic q_t small_coef();
        return q_t'($signed($urandom_range(0, 1 << 27)) - (1 << 26));
    endfunction

    // random pixels: mostly inside a plausible frame, some anywhere
    task automatic queue_random(input int n);
        logic [23:0] px, py;
        for (int i = 0; i < n; i++)
        begin
            if ($urandom_range(3) == 0)
            begin
                px = 24'($urandom);
                py = 24'($urandom);
            end
            else
            begin
                px = lens_pp[23:0] + 24'($signed($urandom_range(0, 4000 * 1024))
                                         - 2000 * 1024);
                py = lens_pp[47:24] + 24'($signed($urandom_range(0, 4000 * 1024))
                                          - 2000 * 1024);
            end
            pixel_queue.push_back({py, px});
        end
    endtask

    task automatic set_idling(input int mode);
        case (mode % 4)
            0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
            1: begin send_idle_pct = 65; recv_stall_pct = 0;  end
            2: begin send_idle_pct = 0;  recv_stall_pct = 65; end
            default: begin send_idle_pct = 15; recv_stall_pct = 15; end
        endcase
    endtask

    // stimulus
    initial
    begin
        send_idle_pct = 0;
        recv_stall_pct = 0;
        send_pause = 1'b0;
        hold_kick = 1'b0;
        cfg_we = 1'b0;
        cfg_index = REG_FOCAL_X;
        cfg_data = '0;
        lens_fx = 24'd256000;
        lens_fy = 24'd256000;
        lens_pp = '0;
        lens_k1 = '0;
        lens_k2 = '0;
        lens_k3 = '0;
        lens_p1 = '0;
        lens_p2 = '0;
        rst_n = 1'b0;
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;

        // directed, reset lens: field extremes and the origin
        pixel_queue.push_back({24'd0, 24'd0});
        pixel_queue.push_back({24'hffffff, 24'hffffff});
        pixel_queue.push_back({24'd0, 24'hffffff});
        pixel_queue.push_back({24'haaaaaa, 24'h555555});
        pixel_queue.push_back({24'd1024000, 24'd1024000});
        wait_drained();

        // zero radial divisor: k1 = -1 at unit radius
        write_reg(REG_K1, {16'h0, 32'shf0000000});
        pixel_queue.push_back({24'd0, 24'd1024000});
        pixel_queue.push_back({24'd1024000, 24'd0});
        pixel_queue.push_back({24'd512000, 24'd0});
        wait_drained();

        // large radius and strong coefficients at both extremes
        write_lens(24'd256, 24'd256, 48'hffffffffffff, 32'sh7fffffff, 32'sh7fffffff,
                   32'sh7fffffff, 32'sh7fffffff, 32'sh7fffffff);
        pixel_queue.push_back({24'd0, 24'd0});
        pixel_queue.push_back({24'hffffff, 24'hfffff0});
        pixel_queue.push_back({24'hfff000, 24'hffffff});
        wait_drained();
        write_lens(24'hffffff, 24'hffffff, 48'h0, 32'sh80000000, 32'sh80000000,
                   32'sh80000000, 32'sh80000000, 32'sh80000000);
        pixel_queue.push_back({24'd0, 24'd0});
        pixel_queue.push_back({24'hffffff, 24'hffffff});
        pixel_queue.push_back({24'h800000, 24'h000001});
        wait_drained();

        // zero focal length
        write_reg(REG_FOCAL_X, 48'd0);
        pixel_queue.push_back({24'd100, 24'd200});
        wait_drained();
        write_reg(REG_FOCAL_X, 48'd256000);
        write_reg(REG_FOCAL_Y, 48'd0);
        pixel_queue.push_back({24'd300, 24'd400});
        wait_drained();

        // random phases with varied lenses and idling
        for (int ph = 0; ph < 10; ph++)
        begin
            if (ph == 9)
                write_lens(24'hffffff, 24'd256, {24'hffffff, 24'd0}, 32'sh7fffffff,
                           32'sh80000000, 32'sh7fffffff, 32'sh80000000, 32'sh7fffffff);
            else
                write_lens(24'($urandom_range(200 * 256, 4000 * 256)),
                           24'($urandom_range(200 * 256, 4000 * 256)),
                           {24'($urandom_range(0, 3000 * 1024)),
                            24'($urandom_range(0, 3000 * 1024))},
                           small_coef(), small_coef(), small_coef(),
                           small_coef() >>> 3, small_coef() >>> 3);
            set_idling(ph);
            // the hold-off phase needs more words than the pipeline holds
            queue_random((ph == 4) ? 350 : 85);
            if (ph == 4)
            begin
                // long output hold-off; input flows until the pipeline fills
                @(posedge clk);
                hold_kick <= 1'b1;
                @(posedge clk);
                hold_kick <= 1'b0;
            end
            if (ph == 6)
            begin
                // sender pause until the pipeline has emptied
                while (pixel_queue.size() > 55)
                    @(posedge clk);
                send_pause = 1'b1;
                while (s_tvalid || undist_queue.size() > 0)
                    @(posedge clk);
                send_pause = 1'b0;
            end
            wait_drained();
        end

        if (mismatches == 0)
            $display("end of test: clean");
        else
            $display("end of test: mismatches");
        $finish;
    end

endmodule
